// ===== rtl/dmp_pkg.sv =====
// ----------------------------------------------------------------------------
// dmp_pkg: shared types and constants for the dithered multiphase pwm block
// payload structs, mode and kind codes, channel and sequencer encodings
// ----------------------------------------------------------------------------
package dmp_pkg;

	localparam int LEVEL_W          = 12;
	localparam int IN_LEVEL_W       = 16;
	localparam int CMP_W            = 8;
	localparam int PHASE_W          = 4;
	localparam int MODE_W           = 2;
	localparam int DEF_LONG_PHASES  = 16;
	localparam int DEF_SHORT_PHASES = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_LIMIT_RESET = 12'd4080;
	localparam logic [CMP_W-1:0]   CMP_IDLE          = 8'hff;

	// item modes, code 3 is ignored
	localparam logic [MODE_W-1:0] MODE_SET   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LONG  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SHORT = 2'd2;

	localparam logic KIND_LONG  = 1'b0;
	localparam logic KIND_SHORT = 1'b1;

	typedef enum logic [1:0] {
		CH_RED,
		CH_GREEN,
		CH_BLUE
	} color_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [IN_LEVEL_W-1:0] red_level;
		logic [IN_LEVEL_W-1:0] green_level;
		logic [IN_LEVEL_W-1:0] blue_level;
	} item_t;

	typedef struct packed {
		logic              timer_kind;
		logic [CMP_W-1:0]  compare_a;
		logic [CMP_W-1:0]  compare_b;
		logic [PHASE_W-1:0] phase_used;
	} result_t;

	// control from the sequencer to the phase tables
	typedef struct packed {
		logic   wr_en;
		color_t wr_ch;
		logic   rd_en;
		logic   rd_kind;
	} tbl_ctl_t;

endpackage

// ===== rtl/dmp_div.sv =====
// ----------------------------------------------------------------------------
// dmp_div: shared restoring divider
// 12-bit dividend by small divisor, quotient saturated to 8 bits, one bit a cycle
// ----------------------------------------------------------------------------
module dmp_div #(
	parameter int DV_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [dmp_pkg::LEVEL_W-1:0] dividend,
	input  logic [DV_W-1:0]             divisor,
	output logic                        done,
	output logic [dmp_pkg::CMP_W-1:0]   quotient
);

	localparam int CW    = dmp_pkg::CMP_W;
	localparam int HI_W  = dmp_pkg::LEVEL_W - CW;
	localparam int REM_W = (DV_W + 1 > HI_W) ? DV_W + 1 : HI_W;
	localparam int CNT_W = $clog2(CW);

	logic [REM_W-1:0] rem_q;
	logic [CW-1:0]    shift_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;

	logic [REM_W-1:0] hi_ext;
	logic [REM_W-1:0] dv_ext;
	logic [REM_W-1:0] trial;
	logic             ge;
	logic             sat;

	always_comb begin
		hi_ext = REM_W'(dividend[dmp_pkg::LEVEL_W-1:CW]);
		dv_ext = REM_W'(divisor);
		// quotient above 255 whenever the top bits already reach the divisor
		sat    = hi_ext >= dv_ext;
		trial  = {rem_q[REM_W-2:0], shift_q[CW-1]};
		ge     = trial >= dv_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			cnt_q  <= '0;
			run_q  <= !sat;
			done_q <= sat;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(CW - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= hi_ext;
			shift_q <= sat ? dmp_pkg::CMP_IDLE : dividend[CW-1:0];
		end else if (run_q) begin
			rem_q   <= ge ? trial - dv_ext : trial;
			shift_q <= {shift_q[CW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = shift_q;

endmodule

// ===== rtl/dmp_tables.sv =====
// ----------------------------------------------------------------------------
// dmp_tables: per-phase compare tables for red, green and blue
// one write port, one registered read; entries never written read as 255
// ----------------------------------------------------------------------------
module dmp_tables #(
	parameter int LONG_PHASES  = dmp_pkg::DEF_LONG_PHASES,
	parameter int SHORT_PHASES = dmp_pkg::DEF_SHORT_PHASES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dmp_pkg::tbl_ctl_t                    ctl,
	input  logic [$clog2(LONG_PHASES > SHORT_PHASES ?
	                     LONG_PHASES : SHORT_PHASES)-1:0] wr_addr,
	input  logic [dmp_pkg::CMP_W-1:0]            wr_data,
	input  logic [$clog2(LONG_PHASES)-1:0]       rd_long_addr,
	input  logic [$clog2(SHORT_PHASES)-1:0]      rd_short_addr,
	output logic [dmp_pkg::CMP_W-1:0]            rd_a,
	output logic [dmp_pkg::CMP_W-1:0]            rd_b
);

	localparam int LI_W = $clog2(LONG_PHASES);
	localparam int SI_W = $clog2(SHORT_PHASES);
	localparam int CW   = dmp_pkg::CMP_W;

	logic [CW-1:0] red_mem   [LONG_PHASES];
	logic [CW-1:0] green_mem [LONG_PHASES];
	logic [CW-1:0] blue_mem  [SHORT_PHASES];

	logic [LONG_PHASES-1:0]  red_vld_q;
	logic [LONG_PHASES-1:0]  green_vld_q;
	logic [SHORT_PHASES-1:0] blue_vld_q;

	logic [CW-1:0] red_rd_q;
	logic [CW-1:0] green_rd_q;
	logic [CW-1:0] blue_rd_q;
	logic          red_ok_q;
	logic          green_ok_q;
	logic          blue_ok_q;
	logic          kind_q;

	// write and read of the arrays
	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_ch == dmp_pkg::CH_RED) begin
			red_mem[wr_addr[LI_W-1:0]] <= wr_data;
		end
		if (ctl.wr_en && ctl.wr_ch == dmp_pkg::CH_GREEN) begin
			green_mem[wr_addr[LI_W-1:0]] <= wr_data;
		end
		if (ctl.wr_en && ctl.wr_ch == dmp_pkg::CH_BLUE) begin
			blue_mem[wr_addr[SI_W-1:0]] <= wr_data;
		end
		if (ctl.rd_en) begin
			red_rd_q   <= red_mem[rd_long_addr];
			green_rd_q <= green_mem[rd_long_addr];
			blue_rd_q  <= blue_mem[rd_short_addr];
			red_ok_q   <= red_vld_q[rd_long_addr];
			green_ok_q <= green_vld_q[rd_long_addr];
			blue_ok_q  <= blue_vld_q[rd_short_addr];
			kind_q     <= ctl.rd_kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_vld_q   <= '0;
			green_vld_q <= '0;
			blue_vld_q  <= '0;
		end else if (ctl.wr_en) begin
			case (ctl.wr_ch)
				dmp_pkg::CH_RED: begin
					red_vld_q[wr_addr[LI_W-1:0]] <= 1'b1;
				end
				dmp_pkg::CH_GREEN: begin
					green_vld_q[wr_addr[LI_W-1:0]] <= 1'b1;
				end
				dmp_pkg::CH_BLUE: begin
					blue_vld_q[wr_addr[SI_W-1:0]] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (kind_q == dmp_pkg::KIND_SHORT) begin
			rd_a = blue_ok_q ? blue_rd_q : dmp_pkg::CMP_IDLE;
			rd_b = '0;
		end else begin
			rd_a = green_ok_q ? green_rd_q : dmp_pkg::CMP_IDLE;
			rd_b = red_ok_q ? red_rd_q : dmp_pkg::CMP_IDLE;
		end
	end

endmodule

// ===== rtl/dmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmp_ctrl: sequencer for level spreading and timer ticks
// drives the shared divider over every phase share, handles the result word
// ----------------------------------------------------------------------------
module dmp_ctrl #(
	parameter int LONG_PHASES  = dmp_pkg::DEF_LONG_PHASES,
	parameter int SHORT_PHASES = dmp_pkg::DEF_SHORT_PHASES,
	parameter int KW           = $clog2(LONG_PHASES > SHORT_PHASES ?
	                                    LONG_PHASES : SHORT_PHASES),
	parameter int DV_W         = $clog2((LONG_PHASES > SHORT_PHASES ?
	                                     LONG_PHASES : SHORT_PHASES) + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [dmp_pkg::LEVEL_W-1:0]         level_limit,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  dmp_pkg::item_t                      item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output dmp_pkg::result_t                    result,
	output logic                                div_start,
	output logic [dmp_pkg::LEVEL_W-1:0]         div_dividend,
	output logic [DV_W-1:0]                     div_divisor,
	input  logic                                div_done,
	input  logic [dmp_pkg::CMP_W-1:0]           div_quotient,
	output dmp_pkg::tbl_ctl_t                   tbl_ctl,
	output logic [KW-1:0]                       tbl_wr_addr,
	output logic [dmp_pkg::CMP_W-1:0]           tbl_wr_data,
	output logic [$clog2(LONG_PHASES)-1:0]      tbl_rd_long_addr,
	output logic [$clog2(SHORT_PHASES)-1:0]     tbl_rd_short_addr,
	input  logic [dmp_pkg::CMP_W-1:0]           tbl_rd_a,
	input  logic [dmp_pkg::CMP_W-1:0]           tbl_rd_b
);

	localparam int LI_W = $clog2(LONG_PHASES);
	localparam int SI_W = $clog2(SHORT_PHASES);
	localparam int LW   = dmp_pkg::LEVEL_W;
	localparam int PW   = dmp_pkg::PHASE_W;
	localparam int LX_W = LI_W > PW ? LI_W : PW;
	localparam int SX_W = SI_W > PW ? SI_W : PW;

	dmp_pkg::state_t  state_q;
	dmp_pkg::state_t  state_d;
	dmp_pkg::color_t  ch_q;
	logic [KW-1:0]    k_q;
	logic [LW-1:0]    rest_q;
	logic [LW-1:0]    lvl_g_q;
	logic [LW-1:0]    lvl_b_q;
	logic             kind_q;
	logic [LI_W-1:0]  long_idx_q;
	logic [SI_W-1:0]  short_idx_q;
	dmp_pkg::result_t res_q;
	logic             res_vld_q;

	logic             item_acc;
	logic             emit_go;
	logic             k_last;
	logic [DV_W-1:0]  phases_sel;
	logic [LW-1:0]    clamp_r;
	logic [LW-1:0]    clamp_g;
	logic [LW-1:0]    clamp_b;
	logic [LX_W-1:0]  long_x;
	logic [SX_W-1:0]  short_x;

	function automatic logic [dmp_pkg::LEVEL_W-1:0] clamp(
		input logic [dmp_pkg::IN_LEVEL_W-1:0] v,
		input logic [dmp_pkg::LEVEL_W-1:0]    lim
	);
		logic [dmp_pkg::IN_LEVEL_W-1:0] lim_ext;
		lim_ext = dmp_pkg::IN_LEVEL_W'(lim);
		return (v > lim_ext) ? lim : v[dmp_pkg::LEVEL_W-1:0];
	endfunction

	always_comb begin
		clamp_r    = clamp(item.red_level, level_limit);
		clamp_g    = clamp(item.green_level, level_limit);
		clamp_b    = clamp(item.blue_level, level_limit);
		phases_sel = (ch_q == dmp_pkg::CH_BLUE) ? DV_W'(SHORT_PHASES) : DV_W'(LONG_PHASES);
		k_last     = DV_W'(k_q) == phases_sel - DV_W'(1);
		long_x     = LX_W'(long_idx_q);
		short_x    = SX_W'(short_idx_q);
		item_acc   = item_valid && !item_stall;
		emit_go    = (state_q == dmp_pkg::ST_EMIT) && (!res_vld_q || !result_stall);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dmp_pkg::ST_IDLE: begin
				if (item_valid) begin
					if (item.mode == dmp_pkg::MODE_SET) begin
						state_d = dmp_pkg::ST_DIV_GO;
					end else if (item.mode == dmp_pkg::MODE_LONG ||
					             item.mode == dmp_pkg::MODE_SHORT) begin
						state_d = dmp_pkg::ST_READ;
					end
				end
			end
			dmp_pkg::ST_DIV_GO: begin
				state_d = dmp_pkg::ST_DIV_WAIT;
			end
			dmp_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					if (k_last && ch_q == dmp_pkg::CH_BLUE) begin
						state_d = dmp_pkg::ST_IDLE;
					end else begin
						state_d = dmp_pkg::ST_DIV_GO;
					end
				end
			end
			dmp_pkg::ST_READ: begin
				state_d = dmp_pkg::ST_EMIT;
			end
			dmp_pkg::ST_EMIT: begin
				if (emit_go) begin
					state_d = dmp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dmp_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		item_stall        = state_q != dmp_pkg::ST_IDLE;
		div_start         = state_q == dmp_pkg::ST_DIV_GO;
		div_dividend      = rest_q;
		div_divisor       = phases_sel - DV_W'(k_q);
		tbl_ctl.wr_en     = (state_q == dmp_pkg::ST_DIV_WAIT) && div_done;
		tbl_ctl.wr_ch     = ch_q;
		tbl_ctl.rd_en     = state_q == dmp_pkg::ST_READ;
		tbl_ctl.rd_kind   = kind_q;
		tbl_wr_addr       = k_q;
		tbl_wr_data       = ~div_quotient;
		tbl_rd_long_addr  = long_idx_q;
		tbl_rd_short_addr = short_idx_q;
		result_valid      = res_vld_q;
		result            = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmp_pkg::ST_IDLE;
			ch_q        <= dmp_pkg::CH_RED;
			k_q         <= '0;
			kind_q      <= dmp_pkg::KIND_LONG;
			long_idx_q  <= '0;
			short_idx_q <= '0;
			res_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_acc) begin
				ch_q   <= dmp_pkg::CH_RED;
				k_q    <= '0;
				kind_q <= (item.mode == dmp_pkg::MODE_SHORT) ?
				          dmp_pkg::KIND_SHORT : dmp_pkg::KIND_LONG;
			end else if (state_q == dmp_pkg::ST_DIV_WAIT && div_done) begin
				if (k_last) begin
					k_q <= '0;
					case (ch_q)
						dmp_pkg::CH_RED: begin
							ch_q <= dmp_pkg::CH_GREEN;
						end
						dmp_pkg::CH_GREEN: begin
							ch_q <= dmp_pkg::CH_BLUE;
						end
						default: begin
							ch_q <= dmp_pkg::CH_BLUE;
						end
					endcase
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
			if (emit_go) begin
				res_vld_q <= 1'b1;
				if (kind_q == dmp_pkg::KIND_SHORT) begin
					short_idx_q <= (short_idx_q == SI_W'(SHORT_PHASES - 1)) ?
					               '0 : short_idx_q + SI_W'(1);
				end else begin
					long_idx_q <= (long_idx_q == LI_W'(LONG_PHASES - 1)) ?
					              '0 : long_idx_q + LI_W'(1);
				end
			end else if (!result_stall) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// level and result payload
	always_ff @(posedge clk) begin
		if (item_acc) begin
			rest_q  <= clamp_r;
			lvl_g_q <= clamp_g;
			lvl_b_q <= {1'b0, clamp_b[LW-1:1]};
		end else if (state_q == dmp_pkg::ST_DIV_WAIT && div_done) begin
			if (k_last) begin
				rest_q <= (ch_q == dmp_pkg::CH_RED) ? lvl_g_q : lvl_b_q;
			end else begin
				rest_q <= rest_q - LW'(div_quotient);
			end
		end
		if (emit_go) begin
			res_q.timer_kind <= kind_q;
			res_q.compare_a  <= tbl_rd_a;
			res_q.compare_b  <= tbl_rd_b;
			res_q.phase_used <= (kind_q == dmp_pkg::KIND_SHORT) ?
			                    short_x[PW-1:0] : long_x[PW-1:0];
		end
	end

endmodule

// ===== rtl/dithered_rgb_pwm_phase_spreader_core.sv =====
// ----------------------------------------------------------------------------
// dithered_rgb_pwm_phase_spreader_core: multiphase dithered rgb pwm compares
// holds the level limit register and ties sequencer, divider and tables
// usage: item channel (item_valid/item_stall/item) takes one word: a set word
//   clamps red, green and blue to the level limit, halves blue and splits
//   each level into per-phase shares stored as 255 - share; a long or short
//   tick word returns that phase's compare values and advances its index.
//   mode code 3 is dropped without a result. result channel gives one word
//   per tick from an output register, so a stalled receiver does not block
//   a set word; a tick behind a full register waits in the emit state.
//   cfg channel writes the level limit, always ready, take it while idle.
// flow: a tick goes through the read state, where the tables are read into
//   their registers, and the emit state, which loads the output register;
//   the next word is taken once the sequencer is back in idle. a set word
//   runs the shared divider once per share (it finishes early when the
//   quotient saturates), with item_stall high meanwhile.
// reset: tables read as 255, both phase indexes go to 0, the level limit
//   goes to 4080, the output register is emptied.
// ----------------------------------------------------------------------------
module dithered_rgb_pwm_phase_spreader_core #(
	parameter int LONG_PHASES  = dmp_pkg::DEF_LONG_PHASES,
	parameter int SHORT_PHASES = dmp_pkg::DEF_SHORT_PHASES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dmp_pkg::LEVEL_W-1:0] cfg_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  dmp_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output dmp_pkg::result_t            result
);

	// largest phase count sets the divisor and share counter widths
	localparam int MAX_PH = LONG_PHASES > SHORT_PHASES ? LONG_PHASES : SHORT_PHASES;
	localparam int KW     = $clog2(MAX_PH);
	localparam int DV_W   = $clog2(MAX_PH + 1);
	localparam int LI_W   = $clog2(LONG_PHASES);
	localparam int SI_W   = $clog2(SHORT_PHASES);

	logic [dmp_pkg::LEVEL_W-1:0] level_limit_q;

	logic                        div_start;
	logic [dmp_pkg::LEVEL_W-1:0] div_dividend;
	logic [DV_W-1:0]             div_divisor;
	logic                        div_done;
	logic [dmp_pkg::CMP_W-1:0]   div_quotient;

	dmp_pkg::tbl_ctl_t           tbl_ctl;
	logic [KW-1:0]               tbl_wr_addr;
	logic [dmp_pkg::CMP_W-1:0]   tbl_wr_data;
	logic [LI_W-1:0]             tbl_rd_long_addr;
	logic [SI_W-1:0]             tbl_rd_short_addr;
	logic [dmp_pkg::CMP_W-1:0]   tbl_rd_a;
	logic [dmp_pkg::CMP_W-1:0]   tbl_rd_b;

	// limit register, written at any time the port offers a word
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_limit_q <= dmp_pkg::LEVEL_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			level_limit_q <= cfg_data;
		end
	end

	// sequencer: walks every phase share and serves the timer ticks
	dmp_ctrl #(
		.LONG_PHASES  (LONG_PHASES),
		.SHORT_PHASES (SHORT_PHASES),
		.KW           (KW),
		.DV_W         (DV_W)
	) u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.level_limit       (level_limit_q),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.item              (item),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.result            (result),
		.div_start         (div_start),
		.div_dividend      (div_dividend),
		.div_divisor       (div_divisor),
		.div_done          (div_done),
		.div_quotient      (div_quotient),
		.tbl_ctl           (tbl_ctl),
		.tbl_wr_addr       (tbl_wr_addr),
		.tbl_wr_data       (tbl_wr_data),
		.tbl_rd_long_addr  (tbl_rd_long_addr),
		.tbl_rd_short_addr (tbl_rd_short_addr),
		.tbl_rd_a          (tbl_rd_a),
		.tbl_rd_b          (tbl_rd_b)
	);

	// one divider shared by all three colors, share = rest / (phases - k)
	dmp_div #(
		.DV_W (DV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	// inverted share tables, read one phase per tick
	dmp_tables #(
		.LONG_PHASES  (LONG_PHASES),
		.SHORT_PHASES (SHORT_PHASES)
	) u_tables (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (tbl_ctl),
		.wr_addr       (tbl_wr_addr),
		.wr_data       (tbl_wr_data),
		.rd_long_addr  (tbl_rd_long_addr),
		.rd_short_addr (tbl_rd_short_addr),
		.rd_a          (tbl_rd_a),
		.rd_b          (tbl_rd_b)
	);

endmodule
